@@ hdl/upsq_pkg.sv @@
// Shared types and constants for the URI path/query splitter.
// No dependencies; imported by every module in hdl/.
package upsq_pkg;

    // Queue between the classifier and the tokenizer
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    // Configuration
    localparam int          CFG_ADDR_W     = 3;
    localparam int          CFG_IDX_LSB    = 2;
    localparam logic [0:0]  REG_MAX_LEN    = 1'b0;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd2000;
    localparam logic [15:0] COUNT_SAT      = 16'hFFFF;

    // Characters
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd10;

    // Token kinds
    localparam logic [1:0] KIND_PATH  = 2'd0;
    localparam logic [1:0] KIND_KEY   = 2'd1;
    localparam logic [1:0] KIND_VALUE = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_ESCAPE   = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG = 2'd2;
    localparam logic [1:0] ERR_NO_EQ    = 2'd3;

    typedef enum logic [2:0] {
        MODE_PATH  = 3'b001,
        MODE_KEY   = 3'b010,
        MODE_VALUE = 3'b100
    } t_mode;

    typedef enum logic [3:0] {
        ESC_NONE = 4'b0001,
        ESC_HI   = 4'b0010,
        ESC_LO   = 4'b0100,
        ESC_BAD  = 4'b1000
    } t_esc;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_uri;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] token_kind;
        logic       token_end;
        logic       uri_done;
        logic [1:0] error_code;
    } t_result;

    // Beat after classification
    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_uri;
        logic       is_slash;
        logic       is_qmark;
        logic       is_amp;
        logic       is_eq;
        logic       is_pct;
        logic       is_hex;
        logic [3:0] hex_val;
    } t_cls_item;

    typedef struct packed {
        logic push;
        logic full;
    } t_q_wr;

    typedef struct packed {
        logic fire;
        logic emit;
    } t_back_status;

endpackage

@@ hdl/upsq_front.sv @@
// Front end: classifies incoming URI bytes and writes them into the queue.
// Depends on upsq_pkg.
module upsq_front import upsq_pkg::*; (
    input  logic      i_push,
    input  t_in_item  i_item,
    input  logic      i_q_full,
    output t_q_wr     o_q_wr,
    output t_cls_item o_cls
);

    logic [7:0] c;
    logic       is_dig;
    logic       is_up;
    logic       is_lo;
    logic [7:0] hv;

    assign c      = i_item.char_byte;
    assign is_dig = (c >= CH_0)  && (c <= CH_9);
    assign is_up  = (c >= CH_UA) && (c <= CH_UF);
    assign is_lo  = (c >= CH_LA) && (c <= CH_LF);

    always_comb begin
        if (is_dig) begin
            hv = c - CH_0;
        end else if (is_up) begin
            hv = c - CH_UA + HEX_ALPHA_OFS;
        end else if (is_lo) begin
            hv = c - CH_LA + HEX_ALPHA_OFS;
        end else begin
            hv = 8'd0;
        end
    end

    always_comb begin
        o_cls.char_byte  = c;
        o_cls.end_of_uri = i_item.end_of_uri;
        o_cls.is_slash   = (c == CH_SLASH);
        o_cls.is_qmark   = (c == CH_QMARK);
        o_cls.is_amp     = (c == CH_AMP);
        o_cls.is_eq      = (c == CH_EQ);
        o_cls.is_pct     = (c == CH_PCT);
        o_cls.is_hex     = is_dig || is_up || is_lo;
        o_cls.hex_val    = hv[3:0];
    end

    assign o_q_wr.full = i_q_full;
    assign o_q_wr.push = i_push && !i_q_full;

endmodule

@@ hdl/upsq_queue.sv @@
// Short queue of classified beats between front and back end.
// Depends on upsq_pkg.
module upsq_queue import upsq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wr,
    input  t_cls_item i_data,
    input  logic      i_rd,
    output logic      o_full,
    output logic      o_valid,
    output t_cls_item o_data
);

    t_cls_item            r_mem [QDEPTH];
    logic [QPTR_W-1:0]    r_wptr;
    logic [QPTR_W-1:0]    r_rptr;
    logic [QCOUNT_W-1:0]  r_count;

    logic wr_en;
    logic rd_en;

    assign o_full  = (r_count == QCOUNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hdl/upsq_back.sv @@
// Back end: tokenizer state, percent decoding, error tracking, result register.
// Depends on upsq_pkg.
module upsq_back import upsq_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [15:0]  i_max_len,
    input  logic         i_q_valid,
    input  t_cls_item    i_q_data,
    input  logic         i_pop,
    output logic         o_empty,
    output t_result      o_result,
    output t_back_status o_status
);

    t_mode       r_mode,   n_mode;
    t_esc        r_esc,    n_esc;
    logic [3:0]  r_hi,     n_hi;
    logic        r_has,    n_has;
    logic [15:0] r_count,  n_count;
    logic [1:0]  r_err,    n_err;
    logic        r_seen,   n_seen;
    logic        r_valid,  n_valid;
    t_result     r_res,    n_res;

    logic        fire;
    logic        emit;
    logic        data_path;
    t_result     res;
    t_cls_item   q;

    assign q    = i_q_data;
    assign fire = i_q_valid && (!r_valid || i_pop);

    always_comb begin
        n_mode    = r_mode;
        n_esc     = r_esc;
        n_hi      = r_hi;
        n_has     = r_has;
        n_count   = r_count;
        n_err     = r_err;
        n_seen    = r_seen;
        emit      = 1'b0;
        data_path = 1'b0;
        res       = '0;

        if (q.end_of_uri) begin
            emit         = 1'b1;
            res.uri_done = 1'b1;
            if (r_err == ERR_NONE) begin
                if (r_mode == MODE_KEY) begin
                    if (r_has) begin
                        n_err = ERR_NO_EQ;
                    end
                end else if (r_esc != ESC_NONE) begin
                    n_err = ERR_ESCAPE;
                end
            end
            if (n_err != ERR_NONE) begin
                res.error_code = n_err;
            end else if (!r_seen) begin
                // empty URI reads as the root segment
                res.out_byte   = CH_SLASH;
                res.byte_valid = 1'b1;
                res.token_end  = 1'b1;
            end else if (r_mode == MODE_VALUE) begin
                res.token_kind = KIND_VALUE;
                res.token_end  = 1'b1;
            end else if (r_mode == MODE_PATH && r_has) begin
                res.token_end  = 1'b1;
            end
            n_mode  = MODE_PATH;
            n_esc   = ESC_NONE;
            n_hi    = '0;
            n_has   = 1'b0;
            n_count = '0;
            n_err   = ERR_NONE;
            n_seen  = 1'b0;
        end else begin
            n_seen = 1'b1;
            if (r_count >= i_max_len) begin
                n_err = ERR_TOO_LONG;
            end
            if (r_count != COUNT_SAT) begin
                n_count = r_count + 1'b1;
            end
            if (n_err == ERR_NONE) begin
                unique case (r_mode)
                    MODE_KEY: begin
                        res.token_kind = KIND_KEY;
                        if (q.is_amp) begin
                            if (r_has) begin
                                n_err = ERR_NO_EQ;
                            end
                        end else if (q.is_eq) begin
                            if (r_esc != ESC_NONE) begin
                                n_err = ERR_ESCAPE;
                            end else begin
                                n_mode        = MODE_VALUE;
                                emit          = 1'b1;
                                res.token_end = 1'b1;
                                n_has         = 1'b0;
                            end
                        end else if (r_esc != ESC_BAD) begin
                            // bad escape in a key swallows bytes until '=' or '&'
                            data_path = 1'b1;
                        end
                    end
                    MODE_VALUE: begin
                        res.token_kind = KIND_VALUE;
                        if (q.is_amp) begin
                            if (r_esc != ESC_NONE) begin
                                n_err = ERR_ESCAPE;
                            end else begin
                                n_mode        = MODE_KEY;
                                emit          = 1'b1;
                                res.token_end = 1'b1;
                                n_has         = 1'b0;
                            end
                        end else begin
                            data_path = 1'b1;
                        end
                    end
                    MODE_PATH: begin
                        res.token_kind = KIND_PATH;
                        if (q.is_slash) begin
                            if (r_esc != ESC_NONE) begin
                                n_err = ERR_ESCAPE;
                            end else begin
                                emit          = 1'b1;
                                res.token_end = 1'b1;
                                n_has         = 1'b0;
                            end
                        end else if (q.is_qmark) begin
                            if (r_esc != ESC_NONE) begin
                                n_err = ERR_ESCAPE;
                            end else begin
                                n_mode = MODE_KEY;
                                if (r_has) begin
                                    emit          = 1'b1;
                                    res.token_end = 1'b1;
                                    n_has         = 1'b0;
                                end
                            end
                        end else begin
                            data_path = 1'b1;
                        end
                    end
                    default: begin
                        data_path = 1'b0;
                    end
                endcase

                if (data_path) begin
                    n_has = 1'b1;
                    if (r_esc == ESC_NONE) begin
                        if (q.is_pct) begin
                            n_esc = ESC_HI;
                        end else begin
                            emit           = 1'b1;
                            res.out_byte   = q.char_byte;
                            res.byte_valid = 1'b1;
                        end
                    end else if (!q.is_hex) begin
                        if (r_mode == MODE_KEY) begin
                            n_esc = ESC_BAD;
                        end else begin
                            n_err = ERR_ESCAPE;
                        end
                    end else if (r_esc == ESC_HI) begin
                        n_hi  = q.hex_val;
                        n_esc = ESC_LO;
                    end else begin
                        n_esc          = ESC_NONE;
                        emit           = 1'b1;
                        res.out_byte   = {r_hi, q.hex_val};
                        res.byte_valid = 1'b1;
                    end
                end
            end
            if (!emit) begin
                res = '0;
            end
        end
    end

    always_comb begin
        n_valid = (r_valid && !i_pop) || (fire && emit);
        n_res   = (fire && emit) ? res : r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PATH;
            r_esc   <= ESC_NONE;
            r_hi    <= '0;
            r_has   <= 1'b0;
            r_count <= '0;
            r_err   <= ERR_NONE;
            r_seen  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (fire) begin
                r_mode  <= n_mode;
                r_esc   <= n_esc;
                r_hi    <= n_hi;
                r_has   <= n_has;
                r_count <= n_count;
                r_err   <= n_err;
                r_seen  <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_empty       = !r_valid;
    assign o_result      = r_res;
    assign o_status.fire = fire;
    assign o_status.emit = emit;

endmodule

@@ hdl/uri_path_query_splitter_top.sv @@
// Path: an item goes through the queue, then the result register, to the ports.
// Throughput: one item per cycle while results are popped; the tokenizer state
// update in upsq_back is the per-item loop, and a 4-beat queue plus the result
// register decouple the sides.
// Reset: synchronous, active low; clears tokenizer state and the queue,
// and sets max_uri_length to 2000.
module uri_path_query_splitter_top import upsq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_result               o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [15:0]  r_max_len;
    t_q_wr        q_wr;
    t_cls_item    cls;
    logic         q_full;
    logic         q_valid;
    t_cls_item    q_data;
    t_back_status back_st;
    logic         cfg_wr;
    logic         cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[CFG_IDX_LSB] == REG_MAX_LEN);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? {16'd0, r_max_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (cfg_wr) begin
            r_max_len <= pwdata[15:0];
        end
    end

    upsq_front u_front (
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_wr   (q_wr),
        .o_cls    (cls)
    );

    upsq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr.push),
        .i_data  (cls),
        .i_rd    (back_st.fire),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    upsq_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_max_len (r_max_len),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result),
        .o_status  (back_st)
    );

    assign full = q_wr.full;

    // errors are reported only on the end beat
    a_err_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.error_code != ERR_NONE) |-> o_result.uri_done)
        else $error("error code outside end beat");

    a_err_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.error_code != ERR_NONE) |-> !o_result.byte_valid)
        else $error("byte carried with error");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !(back_st.fire && back_st.emit)) |=> empty)
        else $error("result register not drained");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_st.fire && back_st.emit) |=> !empty)
        else $error("emitted result lost");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for uri_path_query_splitter_top: a directed table, then random URIs
// across several max_uri_length settings; result beats checked against a predictor or pinned gold.
// Depends on hdl/upsq_pkg.sv and the top level in hdl/.
`timescale 1ns / 1ps

module tb;
    import upsq_pkg::*;

    localparam int RANDOM_ITEMS = 1950;
    localparam int N_PHASES     = 6;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_LIMIT  = 2000;
    localparam logic [CFG_ADDR_W-1:0] MAX_LEN_ADDR = CFG_ADDR_W'(REG_MAX_LEN) << CFG_IDX_LSB;

    typedef struct packed {
        logic        cfg_wr;
        logic [15:0] cfg_val;
        t_in_item    item;
        logic        pinned;
        t_result     gold;
    } t_step;

    localparam int N_DIRECTED = 28;
    localparam t_step DIRECTED_PLAN [N_DIRECTED] = '{
        // empty URI gives the "/" segment
        '{1'b0, 16'd0, '{8'hA5, 1'b1}, 1'b1, '{CH_SLASH, 1'b1, KIND_PATH, 1'b1, 1'b1, ERR_NONE}},
        // "/", 0x00, "%09?k=%fF&&" then end
        '{1'b0, 16'd0, '{CH_SLASH, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{8'h00, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{CH_PCT, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{CH_0, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{CH_9, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{CH_QMARK, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{8'h6B, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{CH_EQ, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{CH_PCT, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{CH_LF, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{CH_UF, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{CH_AMP, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{CH_AMP, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{8'h00, 1'b1}, 1'b1, '{8'h00, 1'b0, KIND_PATH, 1'b0, 1'b1, ERR_NONE}},
        // bad escape in a key, then '&': piece lacks '='
        '{1'b0, 16'd0, '{CH_QMARK, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{CH_PCT, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{CH_UA, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{8'h67, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{CH_AMP, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{8'hFF, 1'b1}, 1'b1, '{8'h00, 1'b0, KIND_PATH, 1'b0, 1'b1, ERR_NO_EQ}},
        // escape cut off by the end
        '{1'b0, 16'd0, '{CH_PCT, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{CH_LA, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{8'h00, 1'b1}, 1'b1, '{8'h00, 1'b0, KIND_PATH, 1'b0, 1'b1, ERR_ESCAPE}},
        // limit of zero: first char is already too long
        '{1'b1, 16'd0, '0, 1'b0, '0},
        '{1'b0, 16'd0, '{8'hFF, 1'b0}, 1'b0, '0},
        '{1'b0, 16'd0, '{8'h5A, 1'b1}, 1'b1, '{8'h00, 1'b0, KIND_PATH, 1'b0, 1'b1, ERR_TOO_LONG}},
        '{1'b1, MAX_LEN_RESET, '0, 1'b0, '0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    t_in_item              i_item;
    logic                  empty;
    logic                  pop;
    t_result               o_result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    uri_path_query_splitter_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // splitter state as the predictor sees it
    logic [15:0] max_len = MAX_LEN_RESET;
    t_mode       mode    = MODE_PATH;
    t_esc        esc     = ESC_NONE;
    logic [3:0]  nib_hi  = '0;
    logic        tok_nonempty = 1'b0;
    logic [15:0] n_chars = '0;
    logic [1:0]  err_held = ERR_NONE;
    logic        any_char = 1'b0;

    t_result     split_due[$];
    logic [7:0]  uri_q[$];
    int          miss_count  = 0;
    int          items_sent  = 0;
    int          idle_cycles = 0;
    bit          steady      = 1'b0;
    bit          pin_on      = 1'b0;
    t_result     pin_res     = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result close_tok(input logic [1:0] kind);
        t_result r;
        r = '0;
        r.token_kind = kind;
        r.token_end  = 1'b1;
        tok_nonempty = 1'b0;
        return r;
    endfunction

    // returns 1 when the item yields a result beat
    function automatic bit split_step(input t_in_item it, output t_result res);
        logic [7:0] c;
        logic [1:0] kind;
        logic [3:0] nib;
        bit         is_hex;
        res = '0;
        c = it.char_byte;
        if (it.end_of_uri) begin
            if (err_held == ERR_NONE) begin
                if (mode == MODE_KEY) begin
                    if (tok_nonempty) err_held = ERR_NO_EQ;
                end else if (esc != ESC_NONE) begin
                    err_held = ERR_ESCAPE;
                end
            end
            res.uri_done = 1'b1;
            if (err_held != ERR_NONE) begin
                res.error_code = err_held;
            end else if (!any_char) begin
                res.out_byte   = CH_SLASH;
                res.byte_valid = 1'b1;
                res.token_end  = 1'b1;
            end else if (mode == MODE_VALUE) begin
                res.token_kind = KIND_VALUE;
                res.token_end  = 1'b1;
            end else if (mode == MODE_PATH && tok_nonempty) begin
                res.token_end = 1'b1;
            end
            mode = MODE_PATH;
            esc = ESC_NONE;
            nib_hi = '0;
            tok_nonempty = 1'b0;
            n_chars = '0;
            err_held = ERR_NONE;
            any_char = 1'b0;
            return 1'b1;
        end

        any_char = 1'b1;
        if (n_chars >= max_len) err_held = ERR_TOO_LONG;
        if (n_chars != COUNT_SAT) n_chars = n_chars + 16'd1;
        if (err_held != ERR_NONE) return 1'b0;

        if (mode == MODE_KEY) begin
            kind = KIND_KEY;
            if (c == CH_AMP) begin
                if (tok_nonempty) err_held = ERR_NO_EQ;
                return 1'b0;
            end
            if (c == CH_EQ) begin
                if (esc != ESC_NONE) begin
                    err_held = ERR_ESCAPE;
                    return 1'b0;
                end
                mode = MODE_VALUE;
                res = close_tok(KIND_KEY);
                return 1'b1;
            end
            // key already holds a bad escape: swallow until '=' or '&'
            if (esc == ESC_BAD) return 1'b0;
        end else if (mode == MODE_VALUE) begin
            kind = KIND_VALUE;
            if (c == CH_AMP) begin
                if (esc != ESC_NONE) begin
                    err_held = ERR_ESCAPE;
                    return 1'b0;
                end
                mode = MODE_KEY;
                res = close_tok(KIND_VALUE);
                return 1'b1;
            end
        end else begin
            kind = KIND_PATH;
            if (c == CH_SLASH || c == CH_QMARK) begin
                if (esc != ESC_NONE) begin
                    err_held = ERR_ESCAPE;
                    return 1'b0;
                end
                if (c == CH_SLASH) begin
                    res = close_tok(KIND_PATH);
                    return 1'b1;
                end
                mode = MODE_KEY;
                if (!tok_nonempty) return 1'b0;
                res = close_tok(KIND_PATH);
                return 1'b1;
            end
        end

        tok_nonempty = 1'b1;
        if (esc == ESC_NONE) begin
            if (c == CH_PCT) begin
                esc = ESC_HI;
                return 1'b0;
            end
            res.out_byte   = c;
            res.byte_valid = 1'b1;
            res.token_kind = kind;
            return 1'b1;
        end

        is_hex = 1'b1;
        nib = '0;
        if (c >= CH_0 && c <= CH_9) nib = 4'(c - CH_0);
        else if (c >= CH_UA && c <= CH_UF) nib = 4'(c - CH_UA + HEX_ALPHA_OFS);
        else if (c >= CH_LA && c <= CH_LF) nib = 4'(c - CH_LA + HEX_ALPHA_OFS);
        else is_hex = 1'b0;

        if (!is_hex) begin
            if (mode == MODE_KEY) esc = ESC_BAD;
            else err_held = ERR_ESCAPE;
            return 1'b0;
        end
        if (esc == ESC_HI) begin
            nib_hi = nib;
            esc = ESC_LO;
            return 1'b0;
        end
        esc = ESC_NONE;
        res.out_byte   = {nib_hi, nib};
        res.byte_valid = 1'b1;
        res.token_kind = kind;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic miss(input string what, input logic [31:0] want, input logic [31:0] got);
        miss_count++;
        $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    endtask

    // input beats are predicted, result beats checked, all at the rising edge
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        bit      has;
        if (i_rst_n) begin
            if (push && !full) begin
                has = split_step(i_item, want);
                if (has) split_due.insert(split_due.size(), pin_on ? pin_res : want);
            end
            if (pop && !empty) begin
                got = o_result;
                if (split_due.size() == 0) begin
                    miss("unexpected result beat", 32'd0, 32'(got));
                end else begin
                    want = split_due.pop_front();
                    if (got.out_byte !== want.out_byte)
                        miss("out_byte", 32'(want.out_byte), 32'(got.out_byte));
                    if (got.byte_valid !== want.byte_valid)
                        miss("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
                    if (got.token_kind !== want.token_kind)
                        miss("token_kind", 32'(want.token_kind), 32'(got.token_kind));
                    if (got.token_end !== want.token_end)
                        miss("token_end", 32'(want.token_end), 32'(got.token_end));
                    if (got.uri_done !== want.uri_done)
                        miss("uri_done", 32'(want.uri_done), 32'(got.uri_done));
                    if (got.error_code !== want.error_code)
                        miss("error_code", 32'(want.error_code), 32'(got.error_code));
                end
            end
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("%0t: watchdog, no beat for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random pop stalls
    initial begin
        int hold;
        hold = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                pop <= 1'b0;
                hold--;
            end else begin
                pop <= 1'b1;
                if ($urandom_range(0, 3) == 0) hold = pick_gap();
            end
        end
    end

    task automatic send_beat(input t_in_item it, input bit pinned, input t_result gold);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            i_item <= t_in_item'(9'($urandom));
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        pin_on = pinned;
        pin_res = gold;
        items_sent++;
        do @(posedge i_clk); while (full);
    endtask

    task automatic quiesce();
        @(negedge i_clk);
        push <= 1'b0;
        while (split_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // optional write, then a read-back of max_uri_length
    task automatic cfg_access(input bit wr, input logic [15:0] v);
        if (wr) begin
            @(negedge i_clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= MAX_LEN_ADDR;
            pwdata <= 32'(v);
            @(negedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            max_len = v;
        end
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= MAX_LEN_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[15:0] !== v) miss("max_uri_length read", 32'(v), 32'(prdata[15:0]));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void put_char(input logic [7:0] b);
        uri_q.insert(uri_q.size(), b);
    endfunction

    // token text: plain chars, high bytes, percent escapes and, outside paths, some '/' and '?' ('=' only in values)
    function automatic void add_text(input logic [1:0] kind, input int n);
        string      plain;
        int         r;
        logic [3:0] v;
        plain = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-._~!$'()*+,;:@";
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                put_char(CH_PCT);
                repeat (2) begin
                    v = 4'($urandom);
                    if (v < 10) put_char(CH_0 + 8'(v));
                    else if ($urandom_range(0, 1)) put_char(CH_UA + 8'(v) - HEX_ALPHA_OFS);
                    else put_char(CH_LA + 8'(v) - HEX_ALPHA_OFS);
                end
            end else if (r < 25) begin
                put_char(8'($urandom_range(128, 255)));
            end else if (r < 30 && kind != KIND_PATH) begin
                case ($urandom_range(0, 2))
                    0: put_char(CH_SLASH);
                    1: put_char(CH_QMARK);
                    default: put_char(kind == KIND_VALUE ? CH_EQ : CH_QMARK);
                endcase
            end else begin
                put_char(plain[$urandom_range(0, plain.len() - 1)]);
            end
        end
    endfunction

    function automatic logic [7:0] odd_byte();
        case ($urandom_range(0, 13))
            0: return CH_PCT;
            1: return CH_SLASH;
            2: return CH_QMARK;
            3: return CH_AMP;
            4: return CH_EQ;
            5: return 8'h67;
            6: return CH_LA;
            7: return CH_9;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void build_uri();
        int r;
        int n_pieces;
        uri_q.delete();
        r = $urandom_range(0, 99);
        if (r < 10) begin
            repeat ($urandom_range(0, 12)) put_char(odd_byte());
            return;
        end
        if ($urandom_range(0, 4) == 0) add_text(KIND_PATH, $urandom_range(1, 4));
        repeat ($urandom_range(0, 3)) begin
            put_char(CH_SLASH);
            add_text(KIND_PATH, $urandom_range(0, 5));
        end
        if ($urandom_range(0, 2) != 0) begin
            put_char(CH_QMARK);
            n_pieces = $urandom_range(0, 3);
            for (int i = 0; i < n_pieces; i++) begin
                if (i > 0) put_char(CH_AMP);
                if ($urandom_range(0, 9) != 0) begin
                    add_text(KIND_KEY, $urandom_range(0, 4));
                    put_char(CH_EQ);
                    add_text(KIND_VALUE, $urandom_range(0, 4));
                end
            end
        end
        // broken sequences: a stray delimiter or bad hex dropped in
        if (r >= 78) begin
            if (uri_q.size() > 0 && $urandom_range(0, 2) == 0)
                uri_q[$urandom_range(0, uri_q.size() - 1)] = odd_byte();
            else
                uri_q.insert($urandom_range(0, uri_q.size()), odd_byte());
        end
    endfunction

    initial begin
        int budget;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        cfg_access(1'b0, MAX_LEN_RESET);
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED_PLAN[i].cfg_wr) begin
                quiesce();
                cfg_access(1'b1, DIRECTED_PLAN[i].cfg_val);
            end else begin
                send_beat(DIRECTED_PLAN[i].item, DIRECTED_PLAN[i].pinned,
                          DIRECTED_PLAN[i].gold);
            end
        end

        budget = items_sent;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            quiesce();
            case (ph)
                1: cfg_access(1'b1, 16'hFFFF);
                2: cfg_access(1'b1, 16'($urandom_range(4, 24)));
                3: cfg_access(1'b1, 16'd0);
                4: cfg_access(1'b1, 16'd1);
                5: cfg_access(1'b1, MAX_LEN_RESET);
                default: ;
            endcase
            while (items_sent < budget + (ph + 1) * RANDOM_ITEMS / N_PHASES) begin
                steady = ($urandom_range(0, 7) == 0);
                build_uri();
                foreach (uri_q[k]) send_beat({uri_q[k], 1'b0}, 1'b0, '0);
                send_beat({8'($urandom), 1'b1}, 1'b0, '0);
            end
        end
        steady = 1'b0;

        quiesce();
        if (miss_count == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/upsq_pkg.sv
hdl/upsq_front.sv
hdl/upsq_queue.sv
hdl/upsq_back.sv
hdl/uri_path_query_splitter_top.sv
tb/sv/tb.sv
